// ----- sv/hbos_pkg.sv -----
package hbos_pkg;

    localparam int VALUE_W    = 18;
    localparam int COUNT_W    = 19;
    localparam int WORD_W     = 64;
    localparam int LEAF_DEPTH = 4096;
    localparam int MID_DEPTH  = 64;
    localparam int LEAF_AW    = 12;
    localparam int MID_AW     = 6;
    localparam int CURSOR_W   = 19;
    localparam int INDEX_W    = 13;

    // request codes
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_CONTAINS = 3'd2;
    localparam logic [2:0] REQ_GE       = 3'd3;
    localparam logic [2:0] REQ_GT       = 3'd4;
    localparam logic [2:0] REQ_LE       = 3'd5;
    localparam logic [2:0] REQ_LT       = 3'd6;
    localparam logic [2:0] REQ_NONE     = 3'd7;

    // tree levels
    localparam logic [1:0] LVL_LEAF = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_TOP  = 2'd2;
    localparam logic [1:0] LVL_OUT  = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_MID,
        S_ISSUE,
        S_EVAL
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] position;
        logic [COUNT_W-1:0] member_count;
        logic               range_error;
    } rsp_t;

    // lowest set bit; zero word gives 63
    function automatic logic [5:0] low_idx(input logic [WORD_W-1:0] m);
        logic [5:0] r;
        r = 6'd63;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    // highest set bit; zero word gives 0
    function automatic logic [5:0] high_idx(input logic [WORD_W-1:0] m);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (m[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/hierarchical_bitmap_ordered_set_top.sv -----
// Channel   Signals                      Handshake
// --------  ---------------------------  ----------------------------------
// request   start, busy, req             word taken when start && !busy
// result    done, rsp                    one-cycle strobe, cannot be held off
// config    cfg_valid, cfg_ready, cfg_data  written when cfg_valid && cfg_ready
//
// Out-of-range and unknown requests answer on the next cycle. Contains reads the
// leaf word; insert and remove read it and may go on to update the middle and
// top words; a search waits on a memory read at each level step, at most 5
// steps, then strobes the result word. After reset the leaf memory is cleared
// one word a cycle; busy stays high until all 4096 words are clear. Middle
// words carry valid bits; the top word is a register. cfg_ready is always high;
// the user must write the limit only while idle; the block does not enforce it.
module hierarchical_bitmap_ordered_set_top
    import hbos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               done,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [VALUE_W-1:0] cfg_data
);

    state_t state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CURSOR_W-1:0] v_reg, v_next;
    logic                neg_reg, neg_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [MID_AW-1:0]   midx_reg, midx_next;
    logic [LEAF_AW-1:0]  clr_reg, clr_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [MID_DEPTH-1:0] mvalid_reg, mvalid_next;
    logic [VALUE_W-1:0]  umax_reg;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic               leaf_we;
    logic [LEAF_AW-1:0] leaf_waddr, leaf_raddr;
    logic [WORD_W-1:0]  leaf_wdata, leaf_rdata;
    logic               mid_we;
    logic [MID_AW-1:0]  mid_waddr, mid_raddr;
    logic [WORD_W-1:0]  mid_wdata, mid_rdata;

    logic [WORD_W-1:0]   leaf_onehot, mid_onehot, top_onehot;
    logic [WORD_W-1:0]   mid_word, leaf_cleared, mid_cleared;
    logic [INDEX_W-1:0]  idx;
    logic                idx_ok;
    logic                srch_up;
    logic [WORD_W-1:0]   srch_word, srch_mask, srch_m;
    logic [5:0]          hit_bit;
    logic [CURSOR_W-1:0] hit_pos;

    hbos_ram #(.WIDTH(WORD_W), .DEPTH(LEAF_DEPTH)) u_leaf (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    hbos_ram #(.WIDTH(WORD_W), .DEPTH(MID_DEPTH)) u_mid (
        .clk   (clk),
        .we    (mid_we),
        .waddr (mid_waddr),
        .wdata (mid_wdata),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // bit masks for the held request value
    assign leaf_onehot  = 64'd1 << val_reg[5:0];
    assign mid_onehot   = 64'd1 << val_reg[11:6];
    assign top_onehot   = 64'd1 << val_reg[17:12];
    assign mid_word     = mvalid_reg[midx_reg] ? mid_rdata : '0;
    assign leaf_cleared = leaf_rdata & ~leaf_onehot;
    assign mid_cleared  = mid_word & ~mid_onehot;

    // search cursor decode
    assign idx = v_reg[CURSOR_W-1:6];
    always_comb
    begin
        unique case (lvl_reg)
            LVL_LEAF: idx_ok = !idx[INDEX_W-1];
            LVL_MID:  idx_ok = (idx[INDEX_W-1:6] == '0);
            LVL_TOP:  idx_ok = (idx == '0);
            default:  idx_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (lvl_reg)
            LVL_LEAF: srch_word = leaf_rdata;
            LVL_MID:  srch_word = mid_word;
            default:  srch_word = top_reg;
        endcase
    end

    assign srch_up   = (op_reg == REQ_GE) || (op_reg == REQ_GT);
    assign srch_mask = srch_up ? (~64'd0 << v_reg[5:0]) : (~64'd0 >> (6'd63 - v_reg[5:0]));
    assign srch_m    = srch_word & srch_mask;
    assign hit_bit   = srch_up ? low_idx(srch_m) : high_idx(srch_m);
    assign hit_pos   = {idx, hit_bit};

    // sequencer: next state, memory controls, result
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        v_next      = v_reg;
        neg_next    = neg_reg;
        lvl_next    = lvl_reg;
        midx_next   = midx_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        mvalid_next = mvalid_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        leaf_we     = 1'b0;
        leaf_waddr  = val_reg[17:6];
        leaf_wdata  = leaf_rdata | leaf_onehot;
        leaf_raddr  = v_reg[17:6];
        mid_we      = 1'b0;
        mid_waddr   = val_reg[17:12];
        mid_wdata   = mid_word | mid_onehot;
        mid_raddr   = v_reg[11:6];

        unique case (state_reg)
            S_CLEAR:
            begin
                leaf_we    = 1'b1;
                leaf_waddr = clr_reg;
                leaf_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LEAF_AW'(LEAF_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                leaf_raddr = req.value[17:6];
                if (start)
                begin
                    op_next  = req.req_type;
                    val_next = req.value;
                    lvl_next = LVL_LEAF;
                    neg_next = 1'b0;
                    v_next   = {1'b0, req.value};
                    rsp_next.found    = 1'b0;
                    rsp_next.position = '0;
                    rsp_next.range_error = 1'b0;
                    if (req.value > umax_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next.range_error = (req.req_type != REQ_NONE);
                    end
                    else
                    begin
                        unique case (req.req_type)
                            REQ_INSERT, REQ_REMOVE, REQ_CONTAINS: state_next = S_LEAF;
                            REQ_GE, REQ_LE: state_next = S_ISSUE;
                            REQ_GT:
                            begin
                                v_next     = {1'b0, req.value} + 1'b1;
                                state_next = S_ISSUE;
                            end
                            REQ_LT:
                            begin
                                neg_next   = (req.value == '0);
                                v_next     = {1'b0, req.value} - 1'b1;
                                state_next = S_ISSUE;
                            end
                            default: done_next = 1'b1;
                        endcase
                    end
                end
            end

            S_LEAF:
            begin
                mid_raddr = val_reg[17:12];
                midx_next = val_reg[17:12];
                if (op_reg == REQ_CONTAINS)
                begin
                    done_next      = 1'b1;
                    rsp_next.found = leaf_rdata[val_reg[5:0]];
                    state_next     = S_IDLE;
                end
                else if (op_reg == REQ_INSERT)
                begin
                    if (leaf_rdata[val_reg[5:0]])
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        leaf_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = S_MID;
                    end
                end
                else
                begin
                    if (!leaf_rdata[val_reg[5:0]])
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        leaf_we    = 1'b1;
                        leaf_wdata = leaf_cleared;
                        count_next = count_reg - 1'b1;
                        if (leaf_cleared != '0)
                        begin
                            done_next      = 1'b1;
                            rsp_next.found = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_MID;
                        end
                    end
                end
            end

            S_MID:
            begin
                mid_we = 1'b1;
                mvalid_next[midx_reg] = 1'b1;
                if (op_reg == REQ_INSERT)
                begin
                    top_next = top_reg | top_onehot;
                end
                else
                begin
                    mid_wdata = mid_cleared;
                    if (mid_cleared == '0)
                    begin
                        top_next = top_reg & ~top_onehot;
                    end
                end
                done_next      = 1'b1;
                rsp_next.found = 1'b1;
                state_next     = S_IDLE;
            end

            S_ISSUE:
            begin
                midx_next = v_reg[11:6];
                if (neg_reg || !idx_ok)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_ISSUE;
                if (srch_m == '0)
                begin
                    // climb one level
                    lvl_next = lvl_reg + 1'b1;
                    if (srch_up)
                    begin
                        v_next = CURSOR_W'(idx) + 1'b1;
                    end
                    else
                    begin
                        neg_next = (idx == '0);
                        v_next   = CURSOR_W'(idx) - 1'b1;
                    end
                end
                else if (lvl_reg == LVL_LEAF)
                begin
                    done_next         = 1'b1;
                    rsp_next.found    = 1'b1;
                    rsp_next.position = hit_pos[VALUE_W-1:0];
                    state_next        = S_IDLE;
                end
                else
                begin
                    // descend into the child word
                    lvl_next = lvl_reg - 1'b1;
                    v_next   = {hit_pos[INDEX_W-1:0], srch_up ? 6'd0 : 6'd63};
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (done_next)
        begin
            rsp_next.member_count = count_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            top_reg    <= '0;
            mvalid_reg <= '0;
            umax_reg   <= '1;
            done_reg   <= 1'b0;
            lvl_reg    <= LVL_LEAF;
            neg_reg    <= 1'b0;
            op_reg     <= REQ_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            mvalid_reg <= mvalid_next;
            done_reg   <= done_next;
            lvl_reg    <= lvl_next;
            neg_reg    <= neg_next;
            op_reg     <= op_next;
            if (cfg_valid && cfg_ready)
            begin
                umax_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        v_reg    <= v_next;
        midx_reg <= midx_next;
        rsp_reg  <= rsp_next;
    end

    // a range error never reports a hit
    a_err_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.range_error |-> !rsp_reg.found)
        else $error("range error with found set");

    // a nonzero position comes only with a hit
    a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.position != '0) |-> rsp_reg.found)
        else $error("position without hit");

    // count stays within the universe
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(LEAF_DEPTH * WORD_W))
        else $error("member count overflow");

    // evaluation is followed by the next issue or by idle
    a_eval_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |=> (state_reg == S_ISSUE || state_reg == S_IDLE))
        else $error("bad step after evaluation");

endmodule

// ----- sv/hbos_ram.sv -----
module hbos_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/hbos_checker.sv -----
module hbos_checker
    import hbos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  req_t               req,
    input  logic               done,
    input  rsp_t               rsp,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [VALUE_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIVERSE = 262144;

    // shadow of the set contents and the limit
    bit [WORD_W-1:0]  leaf_shadow [LEAF_DEPTH];
    bit [WORD_W-1:0]  mid_shadow [MID_DEPTH];
    bit [WORD_W-1:0]  top_shadow;
    bit [COUNT_W-1:0] count_shadow;
    bit [VALUE_W-1:0] limit_shadow;
    rsp_t             expected_q [$];

    function automatic bit [WORD_W-1:0] level_word(int lvl, int idx);
        if (lvl == 0)
        begin
            return (idx < LEAF_DEPTH) ? leaf_shadow[idx] : '0;
        end
        if (lvl == 1)
        begin
            return (idx < MID_DEPTH) ? mid_shadow[idx] : '0;
        end
        return (idx == 0) ? top_shadow : '0;
    endfunction

    // smallest member at or above v
    function automatic bit find_up(int v, output int hit);
        int lvl;
        int idx;
        int b;
        bit [WORD_W-1:0] m;
        lvl = 0;
        hit = 0;
        for (int s = 0; s < 8; s++)
        begin
            if (lvl >= 3)
            begin
                return 0;
            end
            idx = v >> 6;
            if ((lvl == 0 && idx >= LEAF_DEPTH) || (lvl == 1 && idx >= MID_DEPTH)
                || (lvl == 2 && idx >= 1))
            begin
                return 0;
            end
            m = level_word(lvl, idx) & ({WORD_W{1'b1}} << (v & 63));
            if (m == 0)
            begin
                lvl++;
                v = idx + 1;
            end
            else
            begin
                b = 0;
                while (!m[b])
                begin
                    b++;
                end
                v = idx * 64 + b;
                if (lvl == 0)
                begin
                    hit = v;
                    return 1;
                end
                v = v * 64;
                lvl--;
            end
        end
        return 0;
    endfunction

    // largest member at or below v
    function automatic bit find_down(int v, output int hit);
        int lvl;
        int idx;
        int b;
        bit [WORD_W-1:0] m;
        lvl = 0;
        hit = 0;
        for (int s = 0; s < 8; s++)
        begin
            if (v < 0 || lvl >= 3)
            begin
                return 0;
            end
            idx = v >> 6;
            b = v & 63;
            m = level_word(lvl, idx) & ({WORD_W{1'b1}} >> (63 - b));
            if (m == 0)
            begin
                lvl++;
                v = idx - 1;
            end
            else
            begin
                b = 63;
                while (!m[b])
                begin
                    b--;
                end
                if (lvl == 0)
                begin
                    hit = idx * 64 + b;
                    return 1;
                end
                v = (idx * 64 + b) * 64 + 63;
                lvl--;
            end
        end
        return 0;
    endfunction

    // apply one request to the shadow set and form its answer
    function automatic rsp_t apply_request(req_t r);
        rsp_t a;
        int v;
        int hit;
        int w;
        int m;
        bit present;
        a = '0;
        v = r.value;
        w = v >> 6;
        m = v >> 12;
        present = leaf_shadow[w][v & 63];
        if (v > limit_shadow)
        begin
            a.range_error = (r.req_type != REQ_NONE);
        end
        else if (r.req_type == REQ_INSERT && !present)
        begin
            leaf_shadow[w][v & 63] = 1'b1;
            mid_shadow[m][w & 63] = 1'b1;
            top_shadow[m] = 1'b1;
            count_shadow++;
            a.found = 1'b1;
        end
        else if (r.req_type == REQ_REMOVE && present)
        begin
            leaf_shadow[w][v & 63] = 1'b0;
            if (leaf_shadow[w] == 0)
            begin
                mid_shadow[m][w & 63] = 1'b0;
                if (mid_shadow[m] == 0)
                begin
                    top_shadow[m] = 1'b0;
                end
            end
            count_shadow--;
            a.found = 1'b1;
        end
        else if (r.req_type == REQ_CONTAINS)
        begin
            a.found = present;
        end
        else if (r.req_type == REQ_GE || r.req_type == REQ_GT)
        begin
            if (r.req_type == REQ_GT)
            begin
                v++;
            end
            if (v < UNIVERSE && find_up(v, hit))
            begin
                a.found = 1'b1;
                a.position = VALUE_W'(hit);
            end
        end
        else if (r.req_type == REQ_LE || r.req_type == REQ_LT)
        begin
            if (r.req_type == REQ_LT)
            begin
                v--;
            end
            if (find_down(v, hit))
            begin
                a.found = 1'b1;
                a.position = VALUE_W'(hit);
            end
        end
        a.member_count = count_shadow;
        return a;
    endfunction

    // predict on accepted words, compare on strobed results
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            foreach (leaf_shadow[i]) leaf_shadow[i] = '0;
            foreach (mid_shadow[i]) mid_shadow[i] = '0;
            top_shadow = '0;
            count_shadow = '0;
            limit_shadow = '1;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d actual %0d", want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $error("position: expected %0d actual %0d",
                               want.position, rsp.position);
                        fail_count++;
                    end
                    if (rsp.member_count !== want.member_count)
                    begin
                        $error("member_count: expected %0d actual %0d",
                               want.member_count, rsp.member_count);
                        fail_count++;
                    end
                    if (rsp.range_error !== want.range_error)
                    begin
                        $error("range_error: expected %0d actual %0d",
                               want.range_error, rsp.range_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_q.push_back(apply_request(req));
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_shadow = cfg_data;
            end
            pending = expected_q.size();
        end
    end
endmodule

// ----- tb/tb.sv -----
module tb;
    import hbos_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    req_t               req = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [VALUE_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 burst_left = 0;
    int                 hot_values [16];

    always #2 clk = ~clk;

    hierarchical_bitmap_ordered_set_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    hbos_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // send one request word, with a random gap between bursts
    task automatic send_word(logic [2:0] kind, int v);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(12, 0)) @(negedge clk);
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        start <= 1'b1;
        req <= '{req_type: kind, value: VALUE_W'(v)};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (burst_left == 0)
        begin
            start <= 1'b0;
        end
    endtask

    // let the block drain, then write the limit
    task automatic write_limit(int v);
        start <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= VALUE_W'(v);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random value near a small pool of clusters, sometimes anywhere
    function automatic int pick_value();
        int r;
        r = $urandom_range(9, 0);
        if (r < 6)
        begin
            return (hot_values[$urandom_range(15, 0)] + $urandom_range(130, 0)) & 18'h3FFFF;
        end
        if (r < 8)
        begin
            return $urandom_range(262143, 0);
        end
        return (r == 8) ? $urandom_range(70, 0) : 262143 - $urandom_range(70, 0);
    endfunction

    task automatic random_phase(int n, int insert_bias);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99, 0);
            if (k < insert_bias)
            begin
                send_word(REQ_INSERT, pick_value());
            end
            else if (k < insert_bias + 15)
            begin
                send_word(REQ_REMOVE, pick_value());
            end
            else if (k < 98)
            begin
                send_word(3'($urandom_range(6, 2)), pick_value());
            end
            else
            begin
                send_word(REQ_NONE, pick_value());
            end
        end
    endtask

    initial
    begin
        foreach (hot_values[i]) hot_values[i] = $urandom_range(262143, 0);
        hot_values[0] = 0;
        hot_values[1] = 262143 - 130;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty searches, extremes, all request kinds
        send_word(REQ_GE, 0);
        send_word(REQ_LE, 262143);
        send_word(REQ_LT, 0);
        send_word(REQ_GT, 262143);
        send_word(REQ_INSERT, 0);
        send_word(REQ_INSERT, 262143);
        send_word(REQ_INSERT, 262143);
        send_word(REQ_INSERT, 4096 * 7 + 64 * 5 + 3);
        send_word(REQ_CONTAINS, 262143);
        send_word(REQ_CONTAINS, 1);
        send_word(REQ_GT, 0);
        send_word(REQ_GE, 1);
        send_word(REQ_LT, 262143);
        send_word(REQ_LE, 262142);
        send_word(REQ_LT, 0);
        send_word(REQ_GT, 262143);
        send_word(REQ_REMOVE, 5);
        send_word(REQ_REMOVE, 0);
        send_word(REQ_LE, 100);
        send_word(REQ_NONE, 262143);
        send_word(REQ_NONE, 0);

        // lowered limit: range errors, old members still visible
        write_limit(1000);
        send_word(REQ_INSERT, 1001);
        send_word(REQ_CONTAINS, 262143);
        send_word(REQ_GE, 1000);
        send_word(REQ_INSERT, 1000);
        send_word(REQ_GT, 1000);
        random_phase(200, 45);

        write_limit(0);
        send_word(REQ_INSERT, 0);
        send_word(REQ_LE, 0);
        random_phase(60, 40);

        write_limit($urandom_range(262142, 1));
        random_phase(300, 40);

        write_limit(262143);
        random_phase(400, 35);
        random_phase(150, 10);

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
